>>> src/assert_macros.svh
// Assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define FSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fsp_pkg.sv
`timescale 1ns / 1ps

package fsp_pkg;

  localparam int VAL_W = 16;
  localparam int CNT_W = 8;

  typedef enum logic [9:0] {
    PH_PCT    = 10'b00_0000_0001,
    PH_FLAGS  = 10'b00_0000_0010,
    PH_WDIG   = 10'b00_0000_0100,
    PH_DOT    = 10'b00_0000_1000,
    PH_PSTART = 10'b00_0001_0000,
    PH_PDIG   = 10'b00_0010_0000,
    PH_LEN    = 10'b00_0100_0000,
    PH_AH     = 10'b00_1000_0000,
    PH_AL     = 10'b01_0000_0000,
    PH_SPEC   = 10'b10_0000_0000
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_PCT = 2'd1;
  localparam logic [1:0] ST_EARLY   = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_STAR = 2'd2;

  localparam logic [3:0] LEN_PLAIN = 4'd0;
  localparam logic [3:0] LEN_HH    = 4'd1;
  localparam logic [3:0] LEN_H     = 4'd2;
  localparam logic [3:0] LEN_L     = 4'd3;
  localparam logic [3:0] LEN_LL    = 4'd4;
  localparam logic [3:0] LEN_J     = 4'd5;
  localparam logic [3:0] LEN_T     = 4'd6;
  localparam logic [3:0] LEN_Z     = 4'd7;
  localparam logic [3:0] LEN_BIGL  = 4'd8;
  localparam logic [3:0] LEN_BIGZ  = 4'd9;

  localparam logic [4:0] FLAG_LEFT  = 5'b00001;
  localparam logic [4:0] FLAG_PLUS  = 5'b00010;
  localparam logic [4:0] FLAG_SPACE = 5'b00100;
  localparam logic [4:0] FLAG_ALT   = 5'b01000;
  localparam logic [4:0] FLAG_ZERO  = 5'b10000;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] flags;
    logic [1:0] wkind;
    logic [1:0] pkind;
    logic [3:0] len;
    logic       ovf;
  } ctrl_t;

  localparam ctrl_t CTRL_RST = '{phase: PH_PCT, flags: 5'd0, wkind: KIND_NONE,
                                 pkind: KIND_NONE, len: LEN_PLAIN, ovf: 1'b0};

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       flags;
    logic [1:0]       wkind;
    logic [VAL_W-1:0] wval;
    logic [1:0]       pkind;
    logic [VAL_W-1:0] pval;
    logic [3:0]       len;
    logic [7:0]       spec;
    logic [CNT_W-1:0] nchars;
    logic             ovf;
  } res_t;

  function automatic logic in_conv_set(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      "i", "d", "u", "o", "p", "x", "X", "c", "s", "f", "F", "g",
      "G", "e", "E", "t", "a", "A", "n", "b", "B", "K", "%": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> src/fsp_in_reg.sv
`timescale 1ns / 1ps

module fsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_ch
);

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;
  logic       fire;

  assign in_ready  = !valid_r || adv;
  assign fire      = in_valid && in_ready;
  assign valid_nxt = fire ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ch_r <= in_ch;
    end
  end

  assign s1_valid = valid_r;
  assign s1_ch    = ch_r;

endmodule

>>> src/fsp_step.sv
`timescale 1ns / 1ps

module fsp_step #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_BITS = 8
) (
  input  fsp_pkg::ctrl_t         st,
  input  logic [VALUE_BITS-1:0]  w_acc,
  input  logic [VALUE_BITS-1:0]  p_acc,
  input  logic [COUNT_BITS-1:0]  cnt,
  input  logic [7:0]             ch,
  output fsp_pkg::ctrl_t         st_nxt,
  output logic [VALUE_BITS-1:0]  w_acc_nxt,
  output logic [VALUE_BITS-1:0]  p_acc_nxt,
  output logic [COUNT_BITS-1:0]  cnt_nxt,
  output logic                   emit,
  output fsp_pkg::res_t          res
);

  localparam int MW = VALUE_BITS + 4;

  logic                  is_dig;
  logic [3:0]            digit;
  logic                  flag_hit;
  logic [4:0]            flag_mask;
  logic                  len_hit;
  logic                  at_dot, at_len, at_spec;
  logic [VALUE_BITS-1:0] mac_src;
  logic [MW-1:0]         mac_sum;
  logic                  mac_sat;
  logic [VALUE_BITS-1:0] mac_val;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [VALUE_BITS+fsp_pkg::VAL_W-1:0] w_ext, p_ext;
  logic [COUNT_BITS+fsp_pkg::CNT_W-1:0] c_ext, ci_ext;
  logic                  spec_ok;

  assign is_dig = (ch >= "0") && (ch <= "9");
  assign digit  = ch[3:0];

  always_comb begin
    flag_hit  = 1'b1;
    flag_mask = 5'd0;
    case (ch)
      "-":     flag_mask = fsp_pkg::FLAG_LEFT;
      "+":     flag_mask = fsp_pkg::FLAG_PLUS;
      " ":     flag_mask = fsp_pkg::FLAG_SPACE;
      "#":     flag_mask = fsp_pkg::FLAG_ALT;
      "0":     flag_mask = fsp_pkg::FLAG_ZERO;
      default: flag_hit  = 1'b0;
    endcase
  end

  always_comb begin
    case (ch) inside
      "h", "l", "j", "t", "z", "L", "Z": len_hit = 1'b1;
      default:                           len_hit = 1'b0;
    endcase
  end

  // Fall-through chain: a character not taken by one phase moves on to the next.
  assign at_dot = (st.phase == fsp_pkg::PH_DOT)
               || ((st.phase == fsp_pkg::PH_FLAGS) && !flag_hit && (ch != "*") && !is_dig)
               || ((st.phase == fsp_pkg::PH_WDIG) && !is_dig);
  assign at_len = (st.phase == fsp_pkg::PH_LEN)
               || (at_dot && (ch != "."))
               || ((st.phase == fsp_pkg::PH_PSTART) && (ch != "*") && !is_dig)
               || ((st.phase == fsp_pkg::PH_PDIG) && !is_dig);
  assign at_spec = (st.phase == fsp_pkg::PH_SPEC)
                || (at_len && !len_hit)
                || ((st.phase == fsp_pkg::PH_AH) && (ch != "h"))
                || ((st.phase == fsp_pkg::PH_AL) && (ch != "l"));

  // acc * 10 + digit as two shifted adds, saturate when any of the top bits is set.
  assign mac_src = (st.phase == fsp_pkg::PH_WDIG) ? w_acc :
                   (st.phase == fsp_pkg::PH_PDIG) ? p_acc : '0;
  assign mac_sum = ({4'd0, mac_src} << 3) + ({4'd0, mac_src} << 1) + MW'(digit);
  assign mac_sat = (mac_sum[MW-1:VALUE_BITS] != '0);
  assign mac_val = mac_sat ? '1 : mac_sum[VALUE_BITS-1:0];

  assign cnt_inc = (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);

  assign w_ext  = {{fsp_pkg::VAL_W{1'b0}}, w_acc};
  assign p_ext  = {{fsp_pkg::VAL_W{1'b0}}, p_acc};
  assign c_ext  = {{fsp_pkg::CNT_W{1'b0}}, cnt};
  assign ci_ext = {{fsp_pkg::CNT_W{1'b0}}, cnt_inc};
  assign spec_ok = (ch != 8'd0) && fsp_pkg::in_conv_set(ch);

  always_comb begin
    st_nxt    = st;
    w_acc_nxt = w_acc;
    p_acc_nxt = p_acc;
    cnt_nxt   = cnt;
    emit      = 1'b0;
    res       = '0;

    unique case (st.phase)
      fsp_pkg::PH_PCT: begin
        if (ch == "%") begin
          st_nxt.phase = fsp_pkg::PH_FLAGS;
          cnt_nxt      = COUNT_BITS'(1);
        end else begin
          emit       = 1'b1;
          res.status = fsp_pkg::ST_NOT_PCT;
          st_nxt     = fsp_pkg::CTRL_RST;
          w_acc_nxt  = '0;
          p_acc_nxt  = '0;
          cnt_nxt    = '0;
        end
      end
      fsp_pkg::PH_FLAGS: begin
        if (flag_hit) begin
          st_nxt.flags = st.flags | flag_mask;
          cnt_nxt      = cnt_inc;
        end else if (ch == "*") begin
          st_nxt.wkind = fsp_pkg::KIND_STAR;
          st_nxt.phase = fsp_pkg::PH_DOT;
          cnt_nxt      = cnt_inc;
        end else if (is_dig) begin
          st_nxt.wkind = fsp_pkg::KIND_NUM;
          st_nxt.phase = fsp_pkg::PH_WDIG;
          st_nxt.ovf   = st.ovf | mac_sat;
          w_acc_nxt    = mac_val;
          cnt_nxt      = cnt_inc;
        end
      end
      fsp_pkg::PH_WDIG: begin
        if (is_dig) begin
          st_nxt.ovf = st.ovf | mac_sat;
          w_acc_nxt  = mac_val;
          cnt_nxt    = cnt_inc;
        end
      end
      fsp_pkg::PH_PSTART: begin
        st_nxt.pkind = fsp_pkg::KIND_NUM;
        p_acc_nxt    = '0;
        if (ch == "*") begin
          st_nxt.pkind = fsp_pkg::KIND_STAR;
          st_nxt.phase = fsp_pkg::PH_LEN;
          cnt_nxt      = cnt_inc;
        end else if (is_dig) begin
          st_nxt.phase = fsp_pkg::PH_PDIG;
          st_nxt.ovf   = st.ovf | mac_sat;
          p_acc_nxt    = mac_val;
          cnt_nxt      = cnt_inc;
        end
      end
      fsp_pkg::PH_PDIG: begin
        if (is_dig) begin
          st_nxt.ovf = st.ovf | mac_sat;
          p_acc_nxt  = mac_val;
          cnt_nxt    = cnt_inc;
        end
      end
      fsp_pkg::PH_AH: begin
        if (ch == "h") begin
          st_nxt.len   = fsp_pkg::LEN_HH;
          st_nxt.phase = fsp_pkg::PH_SPEC;
          cnt_nxt      = cnt_inc;
        end else begin
          st_nxt.len = fsp_pkg::LEN_H;
        end
      end
      fsp_pkg::PH_AL: begin
        if (ch == "l") begin
          st_nxt.len   = fsp_pkg::LEN_LL;
          st_nxt.phase = fsp_pkg::PH_SPEC;
          cnt_nxt      = cnt_inc;
        end else begin
          st_nxt.len = fsp_pkg::LEN_L;
        end
      end
      default: begin
      end
    endcase

    if (at_dot && (ch == ".")) begin
      st_nxt.phase = fsp_pkg::PH_PSTART;
      cnt_nxt      = cnt_inc;
    end

    if (at_len && len_hit) begin
      cnt_nxt      = cnt_inc;
      st_nxt.phase = fsp_pkg::PH_SPEC;
      case (ch)
        "h":     st_nxt.phase = fsp_pkg::PH_AH;
        "l":     st_nxt.phase = fsp_pkg::PH_AL;
        "j":     st_nxt.len   = fsp_pkg::LEN_J;
        "t":     st_nxt.len   = fsp_pkg::LEN_T;
        "z":     st_nxt.len   = fsp_pkg::LEN_Z;
        "L":     st_nxt.len   = fsp_pkg::LEN_BIGL;
        default: st_nxt.len   = fsp_pkg::LEN_BIGZ;
      endcase
    end

    if (at_spec) begin
      emit       = 1'b1;
      res.flags  = st_nxt.flags;
      res.wkind  = st_nxt.wkind;
      res.wval   = (st_nxt.wkind == fsp_pkg::KIND_NUM) ? w_ext[fsp_pkg::VAL_W-1:0] : '0;
      res.pkind  = st_nxt.pkind;
      res.pval   = (st_nxt.pkind == fsp_pkg::KIND_NUM) ? p_ext[fsp_pkg::VAL_W-1:0] : '0;
      res.len    = st_nxt.len;
      res.ovf    = st_nxt.ovf;
      if (ch == 8'd0) begin
        res.status = fsp_pkg::ST_EARLY;
        res.nchars = c_ext[fsp_pkg::CNT_W-1:0];
      end else if (spec_ok) begin
        res.status = fsp_pkg::ST_OK;
        res.spec   = ch;
        res.nchars = ci_ext[fsp_pkg::CNT_W-1:0];
      end else begin
        res.status = fsp_pkg::ST_BAD;
        res.nchars = c_ext[fsp_pkg::CNT_W-1:0];
      end
      st_nxt    = fsp_pkg::CTRL_RST;
      w_acc_nxt = '0;
      p_acc_nxt = '0;
      cnt_nxt   = '0;
    end
  end

endmodule

>>> src/printf_format_spec_parser.sv
`timescale 1ns / 1ps

// printf conversion specification parser, one character per transaction.
// Input channel (in_valid/in_ready/in_ch): the format string, one byte per
// transaction; a zero byte marks the end of the string. Output channel
// (out_valid/out_ready/out_*): one result transaction per finished or failed
// specification, carrying status, flags, width, precision, length modifier,
// conversion character, consumed character count and an overflow flag.
// A result is valid once the character completing the specification has
// passed the input register and then the parse logic into the result
// register. Throughput: one character per cycle while out_ready is high; the
// parser state update and the multiply-by-ten digit accumulate sit in a single
// stage, so the feedback loop closes through the parser state registers alone.
// Reset (synchronous, active low) returns the parser to waiting for '%',
// clears all accumulators and empties both registers.
// Receiver stall: a pending result holds in the output register; the input
// register keeps accepting until it holds one character that cannot advance,
// then in_ready drops until out_ready returns.
module printf_format_spec_parser #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_flag_bits,
  output logic [1:0]  out_width_kind,
  output logic [15:0] out_width_value,
  output logic [1:0]  out_precision_kind,
  output logic [15:0] out_precision_value,
  output logic [3:0]  out_length_code,
  output logic [7:0]  out_specifier_char,
  output logic [7:0]  out_token_chars,
  output logic        out_number_overflow
);

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       adv;

  // Parser state
  fsp_pkg::ctrl_t        st_r, st_nxt;
  logic [VALUE_BITS-1:0] w_acc_r, w_acc_nxt;
  logic [VALUE_BITS-1:0] p_acc_r, p_acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  // Result register
  logic          emit;
  fsp_pkg::res_t res_nxt;
  fsp_pkg::res_t res_r;
  logic          out_valid_r, out_valid_nxt;

  // Advance the held character whenever the result slot is free or draining.
  assign adv = s1_valid && (!out_valid_r || out_ready);

  fsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_ch    (s1_ch)
  );

  fsp_step #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .st        (st_r),
    .w_acc     (w_acc_r),
    .p_acc     (p_acc_r),
    .cnt       (cnt_r),
    .ch        (s1_ch),
    .st_nxt    (st_nxt),
    .w_acc_nxt (w_acc_nxt),
    .p_acc_nxt (p_acc_nxt),
    .cnt_nxt   (cnt_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  // Hold the parser state unless a character advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= fsp_pkg::CTRL_RST;
      w_acc_r <= '0;
      p_acc_r <= '0;
      cnt_r   <= '0;
    end else if (adv) begin
      st_r    <= st_nxt;
      w_acc_r <= w_acc_nxt;
      p_acc_r <= p_acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Load a new result when one is produced; drop valid once it is taken.
  assign out_valid_nxt = (adv && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_flag_bits       = res_r.flags;
  assign out_width_kind      = res_r.wkind;
  assign out_width_value     = res_r.wval;
  assign out_precision_kind  = res_r.pkind;
  assign out_precision_value = res_r.pval;
  assign out_length_code     = res_r.len;
  assign out_specifier_char  = res_r.spec;
  assign out_token_chars     = res_r.nchars;
  assign out_number_overflow = res_r.ovf;

endmodule

>>> src/fsp_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [4:0]  out_flag_bits,
  input logic [1:0]  out_width_kind,
  input logic [15:0] out_width_value,
  input logic [1:0]  out_precision_kind,
  input logic [15:0] out_precision_value,
  input logic [3:0]  out_length_code,
  input logic [7:0]  out_specifier_char,
  input logic [7:0]  out_token_chars,
  input logic        out_number_overflow
);

  logic not_pct_clean;
  logic spec_nonzero;
  logic stalled;
  logic is_not_pct;
  logic is_ok;
  logic is_fail;
  logic no_num_w;
  logic ok_shape;

  assign not_pct_clean = (out_flag_bits == 5'd0)
                      && (out_width_kind == fsp_pkg::KIND_NONE)
                      && (out_width_value == 16'd0)
                      && (out_precision_kind == fsp_pkg::KIND_NONE)
                      && (out_precision_value == 16'd0)
                      && (out_length_code == fsp_pkg::LEN_PLAIN)
                      && (out_specifier_char == 8'd0) && (out_token_chars == 8'd0)
                      && !out_number_overflow;
  assign spec_nonzero = (out_specifier_char != 8'd0);
  assign stalled      = out_valid && !out_ready;
  assign is_not_pct   = out_valid && (out_status == fsp_pkg::ST_NOT_PCT);
  assign is_ok        = out_valid && (out_status == fsp_pkg::ST_OK);
  assign is_fail      = out_valid && (out_status != fsp_pkg::ST_OK);
  assign no_num_w     = out_valid && (out_width_kind != fsp_pkg::KIND_NUM);
  assign ok_shape     = spec_nonzero && (out_token_chars >= 8'd2);

  `FSP_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_status), "stalled result lost")
  `FSP_ASSERT_IMP(a_not_pct, is_not_pct, not_pct_clean, "non-percent result carries fields")
  `FSP_ASSERT_IMP(a_ok_spec, is_ok, ok_shape, "accepted token lacks specifier or count")
  `FSP_ASSERT_IMP(a_fail_spec, is_fail, !spec_nonzero, "failed token carries specifier")
  `FSP_ASSERT_IMP(a_wval, no_num_w, out_width_value == 16'd0, "width value without width")

endmodule

bind printf_format_spec_parser fsp_checker u_fsp_checker (.*);
